>>> hw/rtl/source_char_lexer_assert.svh
// assertion macros used by the lexer checker
`ifndef SOURCE_CHAR_LEXER_ASSERT_SVH
`define SOURCE_CHAR_LEXER_ASSERT_SVH

// same-cycle implication
`define SCL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SCL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/scl_pkg.sv
// shared types and constants of the source character lexer
package scl_pkg;

   localparam int NAME_CHARS   = 8;
   localparam int NAME_IDX_W   = $clog2(NAME_CHARS);
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_IDX_W  = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      KIND_EOF     = 3'd0,
      KIND_SINGLE  = 3'd1,
      KIND_LITERAL = 3'd2,
      KIND_NAME    = 3'd3,
      KIND_TYPE    = 3'd4,
      KIND_ERROR   = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type     kind;
      logic [15:0]  value;
      logic [63:0]  text;
      logic [7:0]   length;
      logic         truncated;
      logic [15:0]  line;
      logic         last;
   } token_type;

   typedef struct packed {
      token_type first;
      logic      first_valid;
      token_type second;
      logic      second_valid;
   } token_pair_type;

endpackage

>>> hw/rtl/scl_req_if.sv
// input channel: one source byte or end-of-stream mark per beat
interface scl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       end_of_stream;

   modport source (output valid, character, end_of_stream, input ready);
   modport sink (input valid, character, end_of_stream, output ready);
endinterface

>>> hw/rtl/scl_rsp_if.sv
// result channel: one token per beat
interface scl_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [15:0] token_value;
   logic [63:0] name_text;
   logic [7:0]  name_length;
   logic        truncated;
   logic [15:0] line_number;
   logic        last_of_run;

   modport source (output valid, token_kind, token_value, name_text, name_length,
                   truncated, line_number, last_of_run, input ready);
   modport sink (input valid, token_kind, token_value, name_text, name_length,
                 truncated, line_number, last_of_run, output ready);
endinterface

>>> hw/rtl/scl_step.sv
// lexer state and the per-byte token logic
module scl_step (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  logic [7:0]            char_in,
   input  logic                  eos_in,
   output scl_pkg::token_pair_type pair
);

   typedef enum logic [4:0] {
      MODE_IDLE       = 5'b00001,
      MODE_NUMBER     = 5'b00010,
      MODE_QUOTE_OPEN = 5'b00100,
      MODE_QUOTE_CHAR = 5'b01000,
      MODE_WORD       = 5'b10000
   } mode_type;

   localparam logic [7:0]  CHAR_TAB     = 8'h09;
   localparam logic [7:0]  CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0]  CHAR_VTAB    = 8'h0B;
   localparam logic [7:0]  CHAR_FEED    = 8'h0C;
   localparam logic [7:0]  CHAR_RETURN  = 8'h0D;
   localparam logic [7:0]  CHAR_SPACE   = 8'h20;
   localparam logic [7:0]  CHAR_QUOTE   = 8'h27;
   localparam logic [7:0]  CHAR_LPAREN  = 8'h28;
   localparam logic [7:0]  CHAR_RPAREN  = 8'h29;
   localparam logic [7:0]  CHAR_PLUS    = 8'h2B;
   localparam logic [7:0]  CHAR_MINUS   = 8'h2D;
   localparam logic [7:0]  CHAR_ZERO    = 8'h30;
   localparam logic [7:0]  CHAR_NINE    = 8'h39;
   localparam logic [7:0]  CHAR_SEMI    = 8'h3B;
   localparam logic [7:0]  CHAR_EQUAL   = 8'h3D;
   localparam logic [7:0]  CHAR_LBRACE  = 8'h7B;
   localparam logic [7:0]  CHAR_RBRACE  = 8'h7D;
   localparam logic [31:0] KW_NONE      = 32'h656E6F6E;
   localparam logic [31:0] KW_BYTE      = 32'h65747962;
   localparam logic [15:0] KWVAL_NONE   = 16'd0;
   localparam logic [15:0] KWVAL_BYTE   = 16'd1;
   localparam logic [15:0] LINE_MAX     = 16'hFFFF;
   localparam logic [7:0]  LENGTH_MAX   = 8'hFF;
   localparam logic [7:0]  NAME_LIMIT   = 8'(scl_pkg::NAME_CHARS);

   mode_type    mode_ff, mode_in;
   logic [15:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic [7:0]  word_len_ff, word_len_in;
   logic [7:0]  lit_ff, lit_in;
   logic [15:0] line_ff, line_in;
   logic [7:0]  word_ff [scl_pkg::NAME_CHARS];

   logic                          wr_en;
   logic [scl_pkg::NAME_IDX_W-1:0] wr_idx;
   logic                          do_idle;

   logic        is_space, is_single, is_digit;
   logic [19:0] acc_wide, acc_mul;
   logic        acc_over;
   logic [63:0] word_text;

   scl_pkg::token_type idle_tok, num_tok, word_tok, quote_tok, blank_tok;
   logic               idle_tok_valid;

   assign is_space = (char_in == CHAR_SPACE) || (char_in == CHAR_TAB) ||
                     (char_in == CHAR_NEWLINE) || (char_in == CHAR_VTAB) ||
                     (char_in == CHAR_FEED) || (char_in == CHAR_RETURN);
   assign is_single = (char_in == CHAR_LPAREN) || (char_in == CHAR_RPAREN) ||
                      (char_in == CHAR_LBRACE) || (char_in == CHAR_RBRACE) ||
                      (char_in == CHAR_MINUS) || (char_in == CHAR_PLUS) ||
                      (char_in == CHAR_EQUAL) || (char_in == CHAR_SEMI);
   assign is_digit = (char_in >= CHAR_ZERO) && (char_in <= CHAR_NINE);

   // times ten plus digit, saturating
   assign acc_wide = 20'(acc_ff);
   assign acc_mul  = (acc_wide << 3) + (acc_wide << 1) + 20'(char_in - CHAR_ZERO);
   assign acc_over = acc_mul > 20'(LINE_MAX);

   always_comb begin
      word_text = '0;
      for (int i = 0; i < scl_pkg::NAME_CHARS; i++) begin
         if (8'(i) < word_len_ff) begin
            word_text[8*i +: 8] = word_ff[i];
         end
      end
   end

   always_comb begin
      blank_tok = '{kind: scl_pkg::KIND_EOF, value: '0, text: '0, length: '0,
                    truncated: 1'b0, line: line_ff, last: 1'b0};

      idle_tok       = blank_tok;
      idle_tok_valid = eos_in || is_single;
      if (!eos_in) begin
         idle_tok.kind  = scl_pkg::KIND_SINGLE;
         idle_tok.value = 16'(char_in);
      end

      num_tok           = blank_tok;
      num_tok.kind      = scl_pkg::KIND_LITERAL;
      num_tok.value     = acc_ff;
      num_tok.truncated = ovf_ff;

      word_tok           = blank_tok;
      word_tok.kind      = scl_pkg::KIND_NAME;
      word_tok.text      = word_text;
      word_tok.length    = word_len_ff;
      word_tok.truncated = word_len_ff > NAME_LIMIT;
      if (word_len_ff == 8'd4 && word_text[31:0] == KW_NONE) begin
         word_tok.kind  = scl_pkg::KIND_TYPE;
         word_tok.value = KWVAL_NONE;
      end else if (word_len_ff == 8'd4 && word_text[31:0] == KW_BYTE) begin
         word_tok.kind  = scl_pkg::KIND_TYPE;
         word_tok.value = KWVAL_BYTE;
      end

      quote_tok       = blank_tok;
      quote_tok.kind  = scl_pkg::KIND_ERROR;
      quote_tok.value = 16'(lit_ff);
   end

   always_comb begin
      mode_in     = mode_ff;
      acc_in      = acc_ff;
      ovf_in      = ovf_ff;
      word_len_in = word_len_ff;
      lit_in      = lit_ff;
      line_in     = line_ff;
      wr_en       = 1'b0;
      wr_idx      = word_len_ff[scl_pkg::NAME_IDX_W-1:0];
      do_idle     = 1'b0;

      pair.first        = idle_tok;
      pair.first_valid  = 1'b0;
      pair.second       = idle_tok;
      pair.second_valid = 1'b0;

      unique case (mode_ff)
         MODE_NUMBER: begin
            if (!eos_in && is_digit) begin
               acc_in = acc_over ? LINE_MAX : acc_mul[15:0];
               ovf_in = ovf_ff | acc_over;
            end else begin
               pair.first        = num_tok;
               pair.first_valid  = 1'b1;
               pair.second_valid = idle_tok_valid;
               do_idle           = 1'b1;
            end
         end
         MODE_QUOTE_OPEN: begin
            if (eos_in) begin
               mode_in           = MODE_IDLE;
               pair.first        = blank_tok;
               pair.first.kind   = scl_pkg::KIND_ERROR;
               pair.first_valid  = 1'b1;
               pair.second_valid = 1'b1;
            end else begin
               lit_in  = char_in;
               mode_in = MODE_QUOTE_CHAR;
            end
         end
         MODE_QUOTE_CHAR: begin
            mode_in           = MODE_IDLE;
            pair.first        = quote_tok;
            pair.first_valid  = 1'b1;
            pair.second_valid = eos_in;
            if (!eos_in && char_in == CHAR_QUOTE) begin
               pair.first.kind = scl_pkg::KIND_LITERAL;
            end
         end
         MODE_WORD: begin
            if (eos_in || is_single || is_space) begin
               pair.first        = word_tok;
               pair.first_valid  = 1'b1;
               pair.second_valid = idle_tok_valid;
               do_idle           = 1'b1;
            end else begin
               wr_en = word_len_ff < NAME_LIMIT;
               if (word_len_ff != LENGTH_MAX) begin
                  word_len_in = word_len_ff + 8'd1;
               end
            end
         end
         default: begin
            pair.first       = idle_tok;
            pair.first_valid = idle_tok_valid;
            do_idle          = 1'b1;
         end
      endcase

      // ending byte handled as in idle
      if (do_idle) begin
         mode_in = MODE_IDLE;
         if (!eos_in) begin
            priority if (is_space) begin
               if (char_in == CHAR_NEWLINE && line_ff != LINE_MAX) begin
                  line_in = line_ff + 16'd1;
               end
            end else if (is_single) begin
               mode_in = MODE_IDLE;
            end else if (char_in == CHAR_QUOTE) begin
               mode_in = MODE_QUOTE_OPEN;
            end else if (is_digit) begin
               mode_in = MODE_NUMBER;
               acc_in  = 16'(char_in - CHAR_ZERO);
               ovf_in  = 1'b0;
            end else begin
               mode_in     = MODE_WORD;
               wr_en       = 1'b1;
               wr_idx      = '0;
               word_len_in = 8'd1;
            end
         end
      end

      pair.first.last  = !pair.second_valid;
      pair.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         acc_ff      <= '0;
         ovf_ff      <= 1'b0;
         word_len_ff <= '0;
         lit_ff      <= '0;
         line_ff     <= 16'd1;
      end else if (step_en) begin
         mode_ff     <= mode_in;
         acc_ff      <= acc_in;
         ovf_ff      <= ovf_in;
         word_len_ff <= word_len_in;
         lit_ff      <= lit_in;
         line_ff     <= line_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && wr_en) begin
         word_ff[wr_idx] <= char_in;
      end
   end

endmodule

>>> hw/rtl/scl_rsp_queue.sv
// small token queue between the lexer step and the result channel
module scl_rsp_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push_en,
   input  scl_pkg::token_pair_type pair,
   output logic                    room,
   scl_rsp_if.source               rsp_ch
);

   scl_pkg::token_type slot_ff [scl_pkg::QUEUE_DEPTH];

   logic [scl_pkg::QUEUE_IDX_W-1:0] head_ff, head_in;
   logic [scl_pkg::QUEUE_IDX_W-1:0] tail_ff, tail_in, tail_next;
   logic [scl_pkg::QUEUE_CNT_W-1:0] count_ff, count_in, push_cnt;
   logic                            pop;
   scl_pkg::token_type              head_tok;

   assign tail_next = tail_ff + scl_pkg::QUEUE_IDX_W'(1);
   assign pop       = rsp_ch.valid && rsp_ch.ready;
   assign push_cnt  = push_en ? (scl_pkg::QUEUE_CNT_W'(pair.first_valid) +
                                 scl_pkg::QUEUE_CNT_W'(pair.second_valid)) : '0;
   assign count_in  = count_ff + push_cnt - scl_pkg::QUEUE_CNT_W'(pop);
   assign tail_in   = tail_ff + push_cnt[scl_pkg::QUEUE_IDX_W-1:0];
   assign head_in   = head_ff + scl_pkg::QUEUE_IDX_W'(pop);

   // two free entries cover a beat that gives two tokens
   assign room = count_ff <= scl_pkg::QUEUE_CNT_W'(scl_pkg::QUEUE_DEPTH - 2);

   assign head_tok           = slot_ff[head_ff];
   assign rsp_ch.valid       = count_ff != '0;
   assign rsp_ch.token_kind  = head_tok.kind;
   assign rsp_ch.token_value = head_tok.value;
   assign rsp_ch.name_text   = head_tok.text;
   assign rsp_ch.name_length = head_tok.length;
   assign rsp_ch.truncated   = head_tok.truncated;
   assign rsp_ch.line_number = head_tok.line;
   assign rsp_ch.last_of_run = head_tok.last;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_en && pair.first_valid) begin
         slot_ff[tail_ff] <= pair.first;
      end
      if (push_en && pair.second_valid) begin
         slot_ff[tail_next] <= pair.second;
      end
   end

endmodule

>>> hw/rtl/source_char_lexer.sv
// top level of the source character lexer
//
//   channel   direction  beat
//   req_ch    in         one source byte, or end-of-stream mark
//   rsp_ch    out        one token with line number and last-of-run flag
//
// one req beat per cycle while each byte gives at most one token and rsp_ch
// does not stall; a byte that gives two tokens pushes both into the queue together
// tokens pass the input byte register and a queue slot before rsp_ch shows them
// a four-entry token queue parts rsp stalls from req; req stalls when a byte
// waits in the input register and the queue has fewer than two free entries
// synchronous reset clears the mode, counters and queue; line count starts at one
module source_char_lexer (
   input  logic       clock,
   input  logic       reset,
   scl_req_if.sink    req_ch,
   scl_rsp_if.source  rsp_ch
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_eos_ff;
   logic       accept;
   logic       step_en;
   logic       room;

   scl_pkg::token_pair_type pair;

   assign step_en      = in_valid_ff && room;
   assign req_ch.ready = !in_valid_ff || step_en;
   assign accept       = req_ch.valid && req_ch.ready;
   assign in_valid_in  = accept || (in_valid_ff && !step_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_ch.character;
         in_eos_ff  <= req_ch.end_of_stream;
      end
   end

   scl_step u_step (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .char_in (in_char_ff),
      .eos_in  (in_eos_ff),
      .pair    (pair)
   );

   scl_rsp_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push_en (step_en),
      .pair    (pair),
      .room    (room),
      .rsp_ch  (rsp_ch)
   );

endmodule

>>> hw/rtl/scl_checker.sv
// port-level checks of the lexer result channel, bound to the top level
`include "source_char_lexer_assert.svh"

module scl_checker (
   input logic       clock,
   input logic       reset,
   scl_rsp_if.source rsp_ch
);

   logic rsp_beat;
   logic rsp_stall;

   assign rsp_beat  = rsp_ch.valid && rsp_ch.ready;
   assign rsp_stall = rsp_ch.valid && !rsp_ch.ready;

   `SCL_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_stall, rsp_ch.valid && $stable(rsp_ch.token_kind) && $stable(rsp_ch.token_value) && $stable(rsp_ch.name_text) && $stable(rsp_ch.name_length) && $stable(rsp_ch.line_number) && $stable(rsp_ch.last_of_run), "stalled token changed")
   `SCL_ASSERT_NEXT(a_run_follows, clock, reset, rsp_beat && !rsp_ch.last_of_run, rsp_ch.valid, "second token of a run missing")
   `SCL_ASSERT_NEXT(a_error_then_eof, clock, reset, rsp_beat && !rsp_ch.last_of_run && rsp_ch.token_kind == scl_pkg::KIND_ERROR, rsp_ch.token_kind == scl_pkg::KIND_EOF, "open literal error not followed by eof")
   `SCL_ASSERT_NOW(a_line_order, clock, reset, !$past(reset) && $past(rsp_ch.valid) && rsp_ch.valid, rsp_ch.line_number >= $past(rsp_ch.line_number), "line number went back")

endmodule

bind source_char_lexer scl_checker u_scl_checker (
   .clock  (clock),
   .reset  (reset),
   .rsp_ch (rsp_ch)
);

>>> tb/sv/source_char_lexer_test.sv
// self-checking testbench for the source character lexer: directed and random byte streams
module source_char_lexer_test;

   typedef enum logic [4:0] {
      LX_IDLE       = 5'b00001,
      LX_NUMBER     = 5'b00010,
      LX_QUOTE_OPEN = 5'b00100,
      LX_QUOTE_CHAR = 5'b01000,
      LX_WORD       = 5'b10000
   } lex_mode_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_QUOTE   = 8'h27;
   // keywords packed with the first byte lowest
   localparam logic [31:0] KEYWORD_NONE = {"e", "n", "o", "n"};
   localparam logic [31:0] KEYWORD_BYTE = {"e", "t", "y", "b"};

   logic clock = 1'b0;
   logic reset;

   scl_req_if req_ch ();
   scl_rsp_if rsp_ch ();

   source_char_lexer dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   lex_mode_type lex_mode;
   logic [15:0]  number_acc;
   logic         number_ovf;
   logic [7:0]   word_bytes [scl_pkg::NAME_CHARS];
   logic [7:0]   word_len;
   logic [7:0]   quoted_char;
   logic [15:0]  line_cnt;

   scl_pkg::token_type expected_tokens [$];
   scl_pkg::token_type step_tokens [2];
   scl_pkg::token_type want_token;
   int        step_count;
   int        error_count = 0;
   int        quiet_cycles = 0;
   int        send_idle_pct = 0;
   int        rsp_stall_pct = 0;

   always #2 clock = ~clock;

   function automatic logic is_single_char(logic [7:0] c);
      return c inside {"(", ")", "{", "}", "-", "+", "=", ";"};
   endfunction

   function automatic logic is_blank(logic [7:0] c);
      return c inside {" ", 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h0d};
   endfunction

   function automatic logic is_digit(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   task automatic add_token(scl_pkg::kind_type kind, logic [15:0] value,
                            logic [63:0] text, logic [7:0] len, logic trunc);
      scl_pkg::token_type t;
      t.kind = kind;
      t.value = value;
      t.text = text;
      t.length = len;
      t.truncated = trunc;
      t.line = line_cnt;
      t.last = 1'b0;
      step_tokens[step_count] = t;
      step_count++;
   endtask

   task automatic add_word_token();
      logic [63:0]       text;
      scl_pkg::kind_type kind;
      logic [15:0]       value;
      text = '0;
      kind = scl_pkg::KIND_NAME;
      value = '0;
      for (int i = 0; i < scl_pkg::NAME_CHARS; i++)
         if (i < word_len) text[8*i +: 8] = word_bytes[i];
      if (word_len == 8'd4 && text[31:0] == KEYWORD_NONE) begin
         kind = scl_pkg::KIND_TYPE;
      end else if (word_len == 8'd4 && text[31:0] == KEYWORD_BYTE) begin
         kind = scl_pkg::KIND_TYPE;
         value = 16'd1;
      end
      add_token(kind, value, text, word_len, word_len > scl_pkg::NAME_CHARS);
   endtask

   task automatic lex_from_idle(logic [7:0] c, logic eos);
      if (eos) begin
         add_token(scl_pkg::KIND_EOF, '0, '0, '0, 1'b0);
      end else if (is_blank(c)) begin
         if (c == CH_NEWLINE && line_cnt != 16'hffff) line_cnt++;
      end else if (is_single_char(c)) begin
         add_token(scl_pkg::KIND_SINGLE, {8'h00, c}, '0, '0, 1'b0);
      end else if (c == CH_QUOTE) begin
         lex_mode = LX_QUOTE_OPEN;
      end else if (is_digit(c)) begin
         number_acc = {8'h00, c - 8'h30};
         number_ovf = 1'b0;
         lex_mode = LX_NUMBER;
      end else begin
         word_bytes[0] = c;
         word_len = 8'd1;
         lex_mode = LX_WORD;
      end
   endtask

   task automatic lex_predict(logic [7:0] c, logic eos);
      logic [31:0] grown;
      step_count = 0;
      case (lex_mode)
         LX_NUMBER: begin
            if (!eos && is_digit(c)) begin
               grown = 32'(number_acc) * 32'd10 + 32'(c - 8'h30);
               if (grown > 32'hffff) begin
                  grown = 32'hffff;
                  number_ovf = 1'b1;
               end
               number_acc = grown[15:0];
            end else begin
               add_token(scl_pkg::KIND_LITERAL, number_acc, '0, '0, number_ovf);
               lex_mode = LX_IDLE;
               lex_from_idle(c, eos);
            end
         end
         LX_QUOTE_OPEN: begin
            if (eos) begin
               lex_mode = LX_IDLE;
               add_token(scl_pkg::KIND_ERROR, '0, '0, '0, 1'b0);
               add_token(scl_pkg::KIND_EOF, '0, '0, '0, 1'b0);
            end else begin
               quoted_char = c;
               lex_mode = LX_QUOTE_CHAR;
            end
         end
         LX_QUOTE_CHAR: begin
            lex_mode = LX_IDLE;
            if (eos) begin
               add_token(scl_pkg::KIND_ERROR, {8'h00, quoted_char}, '0, '0, 1'b0);
               add_token(scl_pkg::KIND_EOF, '0, '0, '0, 1'b0);
            end else if (c == CH_QUOTE) begin
               add_token(scl_pkg::KIND_LITERAL, {8'h00, quoted_char}, '0, '0, 1'b0);
            end else begin
               add_token(scl_pkg::KIND_ERROR, {8'h00, quoted_char}, '0, '0, 1'b0);
            end
         end
         LX_WORD: begin
            if (eos || is_single_char(c) || is_blank(c)) begin
               add_word_token();
               lex_mode = LX_IDLE;
               lex_from_idle(c, eos);
            end else begin
               if (word_len < scl_pkg::NAME_CHARS) begin
                  word_bytes[word_len[scl_pkg::NAME_IDX_W-1:0]] = c;
               end
               if (word_len != 8'hff) word_len++;
            end
         end
         default: begin
            lex_mode = LX_IDLE;
            lex_from_idle(c, eos);
         end
      endcase
      if (step_count > 0) step_tokens[step_count-1].last = 1'b1;
      for (int i = 0; i < step_count; i++) expected_tokens.push_back(step_tokens[i]);
   endtask

   task automatic compare_field(string field, logic [63:0] want_v, logic [63:0] got_v);
      if (got_v !== want_v) begin
         error_count++;
         $display("%0t %s mismatch: expected %0h, got %0h", $time, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && req_ch.valid === 1'b1 && req_ch.ready === 1'b1)
         lex_predict(req_ch.character, req_ch.end_of_stream);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_tokens.size() == 0) begin
            error_count++;
            $display("%0t unexpected token: expected none, got kind %0d value %0h",
                     $time, rsp_ch.token_kind, rsp_ch.token_value);
         end else begin
            want_token = expected_tokens.pop_front();
            compare_field("token_kind", want_token.kind, rsp_ch.token_kind);
            compare_field("token_value", want_token.value, rsp_ch.token_value);
            compare_field("name_text", want_token.text, rsp_ch.name_text);
            compare_field("name_length", want_token.length, rsp_ch.name_length);
            compare_field("truncated", want_token.truncated, rsp_ch.truncated);
            compare_field("line_number", want_token.line, rsp_ch.line_number);
            compare_field("last_of_run", want_token.last, rsp_ch.last_of_run);
         end
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("source_char_lexer_test: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_beat(logic [7:0] ch, logic eos);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.character <= ch;
      req_ch.end_of_stream <= eos;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   task automatic send_end();
      send_beat(8'($urandom_range(255)), 1'b1);
   endtask

   task automatic wait_all_tokens();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (expected_tokens.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_single_char();
      case ($urandom_range(7))
         0: return "(";
         1: return ")";
         2: return "{";
         3: return "}";
         4: return "-";
         5: return "+";
         6: return "=";
         default: return ";";
      endcase
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(6))
         0: return 8'h09;
         1: return 8'h0b;
         2: return 8'h0c;
         3: return 8'h0d;
         4: return CH_NEWLINE;
         default: return " ";
      endcase
   endfunction

   function automatic logic [7:0] pick_word_byte(logic first);
      logic [7:0] c;
      do c = 8'($urandom_range(255));
      while (is_single_char(c) || is_blank(c) || (first && (is_digit(c) || c == CH_QUOTE)));
      return c;
   endfunction

   task automatic test_single_chars();
      send_text("(){}-+=;");
   endtask

   task automatic test_whitespace();
      send_text(" \t\n\v\f\015x\n;");
   endtask

   task automatic test_numbers();
      send_text("0 65535;65536+007 12ab 99999999");
      send_end();
   endtask

   task automatic test_char_literals();
      send_text("'a''\n''''zq'");
      send_end();
      send_text("'k");
      send_end();
   endtask

   task automatic test_words();
      send_text("none byte;nonex bytes abcdefgh abcdefghi Byte a1'b ");
      send_beat(8'hff, 1'b0);
      send_beat(8'h00, 1'b0);
      send_beat(8'h80, 1'b0);
      send_text(" tail");
      send_end();
      send_end();
   endtask

   task automatic test_long_word();
      send_beat(pick_word_byte(1'b1), 1'b0);
      repeat (299) send_beat(pick_word_byte(1'b0), 1'b0);
      send_text(";");
      wait_all_tokens();
   endtask

   task automatic test_random_stream(int beats, int idle_pct, int stall_pct);
      int sent;
      int n;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      sent = 0;
      while (sent < beats) begin
         case ($urandom_range(9))
            0: begin
               send_beat(pick_single_char(), 1'b0);
               sent++;
            end
            1, 2: begin
               n = $urandom_range(1, ($urandom_range(7) == 0) ? 8 : 4);
               repeat (n) send_beat(8'($urandom_range("0", "9")), 1'b0);
               sent += n;
            end
            3: begin
               send_beat(CH_QUOTE, 1'b0);
               send_beat(8'($urandom_range(255)), 1'b0);
               if ($urandom_range(4) != 0) send_beat(CH_QUOTE, 1'b0);
               else send_beat(8'($urandom_range(255)), 1'b0);
               sent += 3;
            end
            4, 5: begin
               n = $urandom_range(1, 12);
               send_beat(pick_word_byte(1'b1), 1'b0);
               repeat (n - 1) send_beat(pick_word_byte(1'b0), 1'b0);
               sent += n;
            end
            6: send_beat(pick_blank(), 1'b0);
            7: begin
               send_end();
               sent++;
            end
            8: begin
               send_beat(8'($urandom_range(255)), 1'b0);
               sent++;
            end
            default: begin
               if ($urandom_range(1) == 0) send_text("none");
               else send_text("byte");
               sent += 4;
            end
         endcase
         if ($urandom_range(2) == 0) send_beat(pick_blank(), 1'b0);
      end
      wait_all_tokens();
   endtask

   initial begin
      req_ch.valid = 1'b0;
      req_ch.character = 8'h00;
      req_ch.end_of_stream = 1'b0;
      rsp_ch.ready = 1'b0;
      reset = 1'b1;
      lex_mode = LX_IDLE;
      number_acc = '0;
      number_ovf = 1'b0;
      word_len = '0;
      quoted_char = '0;
      line_cnt = 16'd1;
      for (int i = 0; i < scl_pkg::NAME_CHARS; i++) word_bytes[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_single_chars();
      test_whitespace();
      test_numbers();
      test_char_literals();
      test_words();
      test_long_word();
      test_random_stream(245, 0, 0);
      test_random_stream(245, 47, 0);
      test_random_stream(245, 0, 47);
      test_random_stream(245, 32, 32);

      wait_all_tokens();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_tokens.size() == 0)
         $display("source_char_lexer_test: done, clean");
      else
         $display("source_char_lexer_test: done, errors");
      $finish;
   end

endmodule

>>> source_char_lexer.f
+incdir+hw/rtl
hw/rtl/scl_pkg.sv
hw/rtl/scl_req_if.sv
hw/rtl/scl_rsp_if.sv
hw/rtl/scl_step.sv
hw/rtl/scl_rsp_queue.sv
hw/rtl/source_char_lexer.sv
hw/rtl/scl_checker.sv
tb/sv/source_char_lexer_test.sv
